>>> src/qpd_pkg.sv
// Shared constants and helpers for the quaternion packet deframer.
// No dependencies.
package qpd_pkg;

  localparam int unsigned FRAME_BYTES = 14;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned QB_NUM      = 8;

  localparam logic [7:0] START_BYTE = 8'h24;
  localparam logic [7:0] TYPE_BYTE  = 8'h02;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;

  localparam logic [POS_W-1:0] POS_TYPE  = 4'd1;
  localparam logic [POS_W-1:0] POS_QLO   = 4'd2;
  localparam logic [POS_W-1:0] POS_QHI   = 4'd9;
  localparam logic [POS_W-1:0] POS_CR    = 4'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_LF    = 4'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_START = 4'd0;

  localparam logic [3:0] LOCK_RESET = 4'd4;

  // register word index on the config port
  localparam logic REG_LOCK_COUNT = 1'b0;

  localparam int unsigned SUM_W  = 34;
  localparam int unsigned GRAV_W = 18;

  localparam logic signed [SUM_W-1:0] GRAV_MAX = 34'sd131071;
  localparam logic signed [SUM_W-1:0] GRAV_MIN = -34'sd131072;

  function automatic logic signed [GRAV_W-1:0] grav_sat(input logic signed [SUM_W-1:0] v);
    logic signed [GRAV_W-1:0] r;
    if (v > GRAV_MAX) begin
      r = GRAV_MAX[GRAV_W-1:0];
    end else if (v < GRAV_MIN) begin
      r = GRAV_MIN[GRAV_W-1:0];
    end else begin
      r = v[GRAV_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> src/quaternion_packet_deframer.sv
// After its LF is accepted, a frame passes the capture, product and output registers.
// Throughput: one byte per cycle; input stalls only when all three result stages hold
// data that the output side has not taken.
// Stages: frame capture, 16x16 products, sum/round/saturate into the output register.
// Reset: async active low; framing/lock state cleared, lock_match_count set to 4.
// Depends on qpd_pkg.
module quaternion_packet_deframer (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // byte input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  quat_w_o,
  output logic signed [15:0]  quat_x_o,
  output logic signed [15:0]  quat_y_o,
  output logic signed [15:0]  quat_z_o,
  output logic signed [17:0]  grav_x_o,
  output logic signed [17:0]  grav_y_o,
  output logic signed [17:0]  grav_z_o
);
  import qpd_pkg::*;

  // ---------------- config register ----------------
  logic [3:0] lock_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LOCK_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q <= LOCK_RESET;
    end else if (cfg_wr) begin
      lock_q <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_LOCK_COUNT) ? {28'd0, lock_q} : 32'd0;

  // ---------------- pipeline handshake ----------------
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_ready, s2_ready, s1_ready;
  logic in_acc;

  assign out_ready  = !out_v_q || !out_stall_i;
  assign s2_ready   = !s2_v_q || out_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && s1_ready;

  // ---------------- byte framing ----------------
  logic             seen_q, seen_d;
  logic [3:0]       run_q, run_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] pos, pos_inc;
  logic [7:0]       qb_q [QB_NUM];
  logic             qb_we;
  logic [2:0]       qb_idx;
  logic             frame_done;
  logic             active;

  always_comb begin
    pos        = (pos_q >= POS_W'(FRAME_BYTES)) ? POS_START : pos_q;
    pos_inc    = (pos == POS_LF) ? POS_START : pos + POS_W'(1);
    active     = seen_q || (rx_byte_i == START_BYTE);
    seen_d     = seen_q;
    run_d      = run_q;
    pos_d      = pos_q;
    qb_we      = 1'b0;
    qb_idx     = 3'(pos - POS_QLO);
    frame_done = 1'b0;
    if (active) begin
      seen_d = 1'b1;
      pos_d  = pos_inc;
      if (run_q < lock_q) begin
        // still aligning: check header and trailer positions
        priority if (pos == POS_START) begin
          run_d = (rx_byte_i == START_BYTE) ? run_q + 4'd1 : 4'd0;
        end else if (pos == POS_TYPE) begin
          run_d = (rx_byte_i == TYPE_BYTE) ? run_q + 4'd1 : 4'd0;
        end else if (pos == POS_CR) begin
          run_d = (rx_byte_i == CR_BYTE) ? run_q + 4'd1 : 4'd0;
        end else if (pos == POS_LF) begin
          run_d = (rx_byte_i == LF_BYTE) ? run_q + 4'd1 : 4'd0;
        end else begin
          run_d = run_q;
        end
      end else if ((pos == POS_START) && (rx_byte_i != START_BYTE)) begin
        pos_d = POS_START;
      end else begin
        qb_we      = (pos >= POS_QLO) && (pos <= POS_QHI);
        frame_done = (pos == POS_LF);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      run_q  <= 4'd0;
      pos_q  <= POS_START;
    end else if (in_acc) begin
      seen_q <= seen_d;
      run_q  <= run_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && qb_we) begin
      qb_q[qb_idx] <= rx_byte_i;
    end
  end

  // ---------------- stage 1: captured quaternion ----------------
  logic signed [15:0] w1_q, x1_q, y1_q, z1_q;
  logic               s1_load;

  assign s1_load = in_acc && frame_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= s1_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      w1_q <= {qb_q[0], qb_q[1]};
      x1_q <= {qb_q[2], qb_q[3]};
      y1_q <= {qb_q[4], qb_q[5]};
      z1_q <= {qb_q[6], qb_q[7]};
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [15:0] w2_q, x2_q, y2_q, z2_q;
  logic signed [31:0] p_xz_q, p_wy_q, p_wx_q, p_yz_q;
  logic signed [31:0] p_ww_q, p_xx_q, p_yy_q, p_zz_q;
  logic               s2_load;

  assign s2_load = s1_v_q && s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      w2_q   <= w1_q;
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      z2_q   <= z1_q;
      p_xz_q <= x1_q * z1_q;
      p_wy_q <= w1_q * y1_q;
      p_wx_q <= w1_q * x1_q;
      p_yz_q <= y1_q * z1_q;
      p_ww_q <= w1_q * w1_q;
      p_xx_q <= x1_q * x1_q;
      p_yy_q <= y1_q * y1_q;
      p_zz_q <= z1_q * z1_q;
    end
  end

  // ---------------- stage 3: round, saturate, output ----------------
  logic signed [SUM_W-1:0] gx_sum, gy_sum, gz_sum;
  logic signed [SUM_W-1:0] gx_sh, gy_sh, gz_sh;
  logic                    out_load;

  // round to nearest, ties up: add half then floor via arithmetic shift
  always_comb begin
    gx_sum = SUM_W'(p_xz_q) - SUM_W'(p_wy_q) + 34'sd4096;
    gy_sum = SUM_W'(p_wx_q) + SUM_W'(p_yz_q) + 34'sd4096;
    gz_sum = SUM_W'(p_ww_q) - SUM_W'(p_xx_q) - SUM_W'(p_yy_q) + SUM_W'(p_zz_q)
             + 34'sd8192;
    gx_sh  = gx_sum >>> 13;
    gy_sh  = gy_sum >>> 13;
    gz_sh  = gz_sum >>> 14;
  end

  assign out_load = s2_v_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      quat_w_o <= w2_q;
      quat_x_o <= x2_q;
      quat_y_o <= y2_q;
      quat_z_o <= z2_q;
      grav_x_o <= grav_sat(gx_sh);
      grav_y_o <= grav_sat(gy_sh);
      grav_z_o <= grav_sat(gz_sh);
    end
  end

  assign out_valid_o = out_v_q;

  // ---------------- assertions ----------------
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < POS_W'(FRAME_BYTES))
    else $error("byte position out of frame range");

  a_idle_before_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (pos_q == POS_START) && (run_q == 4'd0))
    else $error("framing state moved before first start byte");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_v_q && s2_v_q && out_v_q && out_stall_i))
    else $error("input stalled with room in the result pipeline");

  a_frame_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load |=> s1_v_q)
    else $error("completed frame not captured");

endmodule

>>> tb/quaternion_packet_deframer_tb.sv
// Self-checking testbench for quaternion_packet_deframer: byte stream in, Q14 quaternion
// and saturated gravity vector out, checked against an in-bench frame predictor.
// Depends on qpd_pkg and the deframer RTL only.
module quaternion_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qpd_pkg::*;

  localparam logic [2:0] LOCK_ADDR       = 3'(4 * int'(REG_LOCK_COUNT));
  localparam int         SETTLE_CYCLES   = 8;
  localparam int         HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [17:0] gx;
    logic [17:0] gy;
    logic [17:0] gz;
  } quat_frame_t;

  typedef enum {FLAW_NONE, FLAW_START, FLAW_TYPE, FLAW_CR, FLAW_LF, FLAW_SHORT} frame_flaw_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [2:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] quat_w_o;
  logic signed [15:0] quat_x_o;
  logic signed [15:0] quat_y_o;
  logic signed [15:0] quat_z_o;
  logic signed [17:0] grav_x_o;
  logic signed [17:0] grav_y_o;
  logic signed [17:0] grav_z_o;

  // predictor state
  logic       got_start = 1'b0;
  logic [3:0] sync_hits = '0;
  logic [3:0] byte_slot = '0;
  logic [3:0] lock_need = LOCK_RESET;
  logic [7:0] quat_reg [QB_NUM];

  quat_frame_t pending_frames [$];

  int   err_cnt        = 0;
  int   bytes_sent     = 0;
  int   src_idle_mode  = 1;
  int   sink_idle_mode = 1;
  bit   hold_off_req   = 1'b0;
  logic sink_blocked   = 1'b0;

  quaternion_packet_deframer DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // 0: never idle, 1: idle now and then, 2: a random wait drawn on every word
  function automatic int draw_wait(input int mode);
    case (mode)
      0:       return 0;
      1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  function automatic logic [17:0] q14_sat(input longint v, input int sh);
    longint q;
    q = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (q > GRAV_MAX) q = GRAV_MAX;
    else if (q < GRAV_MIN) q = GRAV_MIN;
    return q[17:0];
  endfunction

  function automatic logic [15:0] pick_quat();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return ($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hC000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    logic [3:0]  slot;
    logic [7:0]  marker;
    bit          is_marker;
    longint      w, x, y, z;
    quat_frame_t f;
    if (!got_start) begin
      if (b != START_BYTE) return;
      got_start = 1'b1;
    end
    slot = (byte_slot >= FRAME_BYTES) ? POS_START : byte_slot;
    if (sync_hits < lock_need) begin
      marker    = '0;
      is_marker = 1'b1;
      case (slot)
        POS_START: marker = START_BYTE;
        POS_TYPE:  marker = TYPE_BYTE;
        POS_CR:    marker = CR_BYTE;
        POS_LF:    marker = LF_BYTE;
        default:   is_marker = 1'b0;
      endcase
      if (is_marker) sync_hits = (b == marker) ? sync_hits + 4'd1 : 4'd0;
      byte_slot = (slot == POS_LF) ? POS_START : slot + 4'd1;
      return;
    end
    // locked: hunt for the start byte, frames themselves are not checked
    if (slot == POS_START && b != START_BYTE) begin
      byte_slot = POS_START;
      return;
    end
    if (slot >= POS_QLO && slot <= POS_QHI) quat_reg[3'(slot - POS_QLO)] = b;
    if (slot != POS_LF) begin
      byte_slot = slot + 4'd1;
      return;
    end
    byte_slot = POS_START;
    w = longint'($signed({quat_reg[0], quat_reg[1]}));
    x = longint'($signed({quat_reg[2], quat_reg[3]}));
    y = longint'($signed({quat_reg[4], quat_reg[5]}));
    z = longint'($signed({quat_reg[6], quat_reg[7]}));
    f.w  = w[15:0];
    f.x  = x[15:0];
    f.y  = y[15:0];
    f.z  = z[15:0];
    f.gx = q14_sat(x * z - w * y, 13);
    f.gy = q14_sat(w * x + y * z, 13);
    f.gz = q14_sat(w * w - x * x - y * y + z * z, 14);
    pending_frames.insert(pending_frames.size(), f);
  endtask

  // valid stays up between back-to-back words; only lowered when a gap is drawn
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(src_idle_mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [63:0] quat, input frame_flaw_e flaw);
    logic [7:0] fr [FRAME_BYTES];
    int         len;
    int         bad_slot;
    fr[POS_START] = START_BYTE;
    fr[POS_TYPE]  = TYPE_BYTE;
    for (int i = 0; i < 8; i++) fr[POS_QLO + i] = quat[63 - 8 * i -: 8];
    fr[POS_CR] = CR_BYTE;
    fr[POS_LF] = LF_BYTE;
    len      = FRAME_BYTES;
    bad_slot = -1;
    case (flaw)
      FLAW_START: bad_slot = POS_START;
      FLAW_TYPE:  bad_slot = POS_TYPE;
      FLAW_CR:    bad_slot = POS_CR;
      FLAW_LF:    bad_slot = POS_LF;
      FLAW_SHORT: len = $urandom_range(1, FRAME_BYTES - 1);
      default:    ;
    endcase
    if (bad_slot >= 0) fr[bad_slot] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < len; i++) send_byte(fr[i]);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_lock_count(input logic [3:0] val);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LOCK_ADDR;
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    lock_need = val;
    // read it back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(val)) begin
      err_cnt++;
      $display("%0t: lock_match_count readback, expected %0d, got %0d", $time, val, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_frame();
    quat_frame_t f;
    if (pending_frames.size() == 0) begin
      err_cnt++;
      $display("%0t: result with no frame pending, expected none, got w=%0d x=%0d y=%0d z=%0d",
               $time, quat_w_o, quat_x_o, quat_y_o, quat_z_o);
      return;
    end
    f = pending_frames.pop_front();
    check_field("quat_w", $signed(f.w), quat_w_o);
    check_field("quat_x", $signed(f.x), quat_x_o);
    check_field("quat_y", $signed(f.y), quat_y_o);
    check_field("quat_z", $signed(f.z), quat_z_o);
    check_field("grav_x", $signed(f.gx), grav_x_o);
    check_field("grav_y", $signed(f.gy), grav_y_o);
    check_field("grav_z", $signed(f.gz), grav_z_o);
  endtask

  // mostly clean frames; realigns while hunting so lock can actually be reached
  task automatic send_traffic(input int n_bytes);
    int          stop_at;
    int          pad;
    frame_flaw_e flaw;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if (sync_hits < lock_need && byte_slot != POS_START && $urandom_range(0, 3) != 0) begin
        pad = FRAME_BYTES - byte_slot;
        repeat (pad) send_byte(8'($urandom));
      end
      case ($urandom_range(0, 11))
        0: repeat ($urandom_range(1, 5))
             send_byte(($urandom_range(0, 2) == 0) ? START_BYTE : 8'($urandom));
        1, 2: begin
          flaw = frame_flaw_e'($urandom_range(FLAW_START, FLAW_SHORT));
          send_frame({pick_quat(), pick_quat(), pick_quat(), pick_quat()}, flaw);
        end
        default: send_frame({pick_quat(), pick_quat(), pick_quat(), pick_quat()}, FLAW_NONE);
      endcase
    end
  endtask

  task automatic test_hunt_and_lock();
    write_lock_count(4'd1);
    src_idle_mode  = 2;
    sink_idle_mode = 2;
    // dropped: no start byte seen yet
    send_byte(8'h00);
    send_byte(8'hFF);
    // first start byte locks at once; gravity x saturates high
    send_frame({16'h8000, 16'h8000, 16'h7FFF, 16'h8000}, FLAW_NONE);
    // locked, not a start byte at slot zero: dropped
    send_byte(8'hA5);
    send_frame({16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000}, FLAW_NONE);
    send_frame({16'h8000, 16'h0000, 16'h0000, 16'h8000}, FLAW_NONE);
  endtask

  task automatic test_full_stall();
    src_idle_mode = 0;
    hold_off_req  = 1'b1;
    // sink held off: back-to-back frames fill the result stages and stall the input
    repeat (10) send_frame({pick_quat(), pick_quat(), pick_quat(), pick_quat()}, FLAW_NONE);
  endtask

  task automatic test_random_traffic();
    logic [3:0] plan [12];
    plan = '{4'd15, 4'd1, 4'd0, 4'd4, 4'd7, 4'd3, 4'd2, 4'd12, 4'd15, 4'd1, 4'd9, 4'd5};
    foreach (plan[i]) begin
      write_lock_count(plan[i]);
      src_idle_mode  = $urandom_range(0, 2);
      sink_idle_mode = $urandom_range(0, 2);
      send_traffic(150);
    end
  endtask

  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        check_frame();
        hold = draw_wait(sink_idle_mode);
      end else if (hold > 0) begin
        hold--;
      end
      out_stall_i <= (hold > 0) || sink_blocked;
    end
  end

  initial begin : sink_hold_off
    wait (hold_off_req);
    @(posedge clk_i);
    sink_blocked <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    sink_blocked <= 1'b0;
  end

  initial begin : watchdog
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : run
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_hunt_and_lock();
    test_full_stall();
    test_random_traffic();
    settle();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
src/qpd_pkg.sv
src/quaternion_packet_deframer.sv
tb/quaternion_packet_deframer_tb.sv
